FILE: sv/egd_pkg.sv
package egd_pkg;

    localparam int DATA_W = 32;

    localparam int RING_DEPTH_DEF = 8;
    localparam int REVERSALS_DEF  = 4;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 3;

    // (steps - 1) * 1e6 * 256
    localparam logic [DATA_W-1:0] VEL_SCALE = 32'd256000000;
    localparam logic [DATA_W-1:0] VEL_MAX   = 32'h7FFF_FFFF;

    // t_ms = (t_us * MS_RECIP) >> MS_SHIFT, exact for any 32-bit t_us
    localparam logic [DATA_W-1:0] MS_RECIP = 32'd274877907;
    localparam int                MS_SHIFT = 38;

    localparam logic [1:0] KIND_STEP = 2'd0;
    localparam logic [1:0] KIND_POLL = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_CW   = 2'b01;

    localparam logic [1:0] GEST_NONE     = 2'd0;
    localparam logic [1:0] GEST_SHAKE    = 2'd1;
    localparam logic [1:0] GEST_BACKSPIN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEPS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_US   = 3'd4;

    localparam logic [15:0] RST_SHAKE_WINDOW = 16'd600;
    localparam logic [15:0] RST_MIN_SPEED    = 16'd30;
    localparam logic [7:0]  RST_MIN_STEPS    = 8'd3;
    localparam logic [15:0] RST_QUIET_MS     = 16'd150;
    localparam logic [31:0] RST_TIMEOUT_US   = 32'd200000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: sv/egd_ram.sv
module egd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/egd_div.sv
module egd_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [egd_pkg::DATA_W-1:0] dividend,
    input  logic [egd_pkg::DATA_W-1:0] divisor,
    output egd_pkg::div_stat_t       stat,
    output logic [egd_pkg::DATA_W-1:0] quotient
);
    import egd_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   shifted;
    logic              ge;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? DATA_W'(shifted - {1'b0, dvs_reg}) : shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");
    a_zero_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> divisor != '0)
        else $error("divider started with zero divisor");
`endif

endmodule

FILE: sv/encoder_gesture_detector_top.sv
// Rotary encoder gesture detector. Step, poll-end and delta-read transactions
// come in on the s_ stream (kind in s_tuser); each gives exactly one result on
// the m_ stream with the gesture code in m_tuser and the velocity and delta in
// m_tdata. One transaction is worked at a time: reads, ignored steps and
// unknown kinds go straight to the result state, poll ends pass the arm and
// check states, and a step passes the ring and oldest-stamp states, waits on
// the divider when a velocity is computed and takes the reversal states when
// the direction reverses. The velocity quotient runs on a restoring divider;
// the reversal time in milliseconds comes from a reciprocal multiply. Step
// times sit in a small RAM with a registered read. A finished result waits
// in an output register while the next transaction is accepted.
module encoder_gesture_detector_top #(
    parameter int RING_DEPTH = egd_pkg::RING_DEPTH_DEF,
    parameter int REVERSALS  = egd_pkg::REVERSALS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // direction[1:0], time_us[33:2], now_ms[65:34], events_seen[66]
    input  logic [egd_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [egd_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // velocity[31:0], delta[39:32]
    output logic [egd_pkg::M_TDATA_W-1:0]   m_tdata,
    // gesture[1:0]
    output logic [egd_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [egd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [egd_pkg::DATA_W-1:0]      cfg_data
);
    import egd_pkg::*;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int RI_W   = $clog2(REVERSALS + 1);
    localparam int RF_W   = $clog2(REVERSALS + 2);
    localparam logic [FILL_W:0] DEPTH_X = (FILL_W + 1)'(RING_DEPTH);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_RING  = 11'b000_0000_0010,
        ST_OLD   = 11'b000_0000_0100,
        ST_VDIV  = 11'b000_0000_1000,
        ST_REV   = 11'b000_0001_0000,
        ST_MDIV  = 11'b000_0010_0000,
        ST_SHAKE = 11'b000_0100_0000,
        ST_BURST = 11'b000_1000_0000,
        ST_PARM  = 11'b001_0000_0000,
        ST_PCHK  = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic              in_neg_reg, in_neg_next;
    logic [DATA_W-1:0] in_time_reg, in_time_next;
    logic [DATA_W-1:0] in_now_reg, in_now_next;
    logic              in_seen_reg, in_seen_next;

    logic [15:0]       cfg_window_reg, cfg_window_next;
    logic [15:0]       cfg_speed_reg, cfg_speed_next;
    logic [7:0]        cfg_steps_reg, cfg_steps_next;
    logic [15:0]       cfg_quiet_reg, cfg_quiet_next;
    logic [DATA_W-1:0] cfg_timeout_reg, cfg_timeout_next;

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic [DATA_W-1:0] num_reg, num_next;
    logic              rev_reg, rev_next;
    logic [DATA_W-1:0] speed_reg, speed_next;
    logic              prior_valid_reg, prior_valid_next;
    logic              prior_neg_reg, prior_neg_next;
    logic [DATA_W-1:0] rev_times_reg [REVERSALS+1];
    logic [DATA_W-1:0] rev_times_next [REVERSALS+1];
    logic [RF_W-1:0]   rev_fill_reg, rev_fill_next;
    logic [DATA_W-1:0] tms_reg, tms_next;
    logic              armed_reg, armed_next;
    logic [7:0]        burst_reg, burst_next;
    logic [DATA_W-1:0] peak_reg, peak_next;
    logic [DATA_W-1:0] quiet_reg, quiet_next;
    logic [7:0]        delta_reg, delta_next;
    logic [1:0]        res_gest_reg, res_gest_next;
    logic [7:0]        res_delta_reg, res_delta_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              div_start;
    logic [DATA_W-1:0] div_dividend, div_divisor, div_quo;
    div_stat_t         div_stat;

    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W:0]   ptr_p1, old_sum;
    logic [DATA_W-1:0] dt, mag, first_rev, neg_speed;
    logic [2*DATA_W-1:0] ms_prod;
    logic              shake_hit, fire, timed_out, burst_fast;
    logic signed [DATA_W:0] speed_x, thr_neg;

    egd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (in_time_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    egd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb begin
        fill_inc  = (fill_reg < FILL_W'(RING_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
        ptr_p1    = (FILL_W + 1)'(ptr_reg) + 1'b1;
        if (ptr_p1 >= {1'b0, fill_inc}) begin
            old_sum = ptr_p1 - {1'b0, fill_inc};
        end else begin
            old_sum = ptr_p1 + DEPTH_X - {1'b0, fill_inc};
        end
        ram_raddr = old_sum[PTR_W-1:0];
        ram_we    = (state_reg == ST_RING);

        dt  = in_time_reg - ram_rdata;
        mag = div_quo[DATA_W-1] ? VEL_MAX : div_quo;

        ms_prod = (2 * DATA_W)'(in_time_reg) * (2 * DATA_W)'(MS_RECIP);

        first_rev = (rev_fill_reg == RF_W'(REVERSALS + 1)) ? rev_times_reg[1]
                                                          : rev_times_reg[0];
        shake_hit = (state_reg == ST_SHAKE) && (rev_fill_reg >= RF_W'(REVERSALS))
                    && ((tms_reg - first_rev) <= {16'd0, cfg_window_reg});

        speed_x    = $signed({speed_reg[DATA_W-1], speed_reg});
        thr_neg    = -$signed({9'd0, cfg_speed_reg, 8'd0});
        burst_fast = in_neg_reg && (speed_x < thr_neg);
        neg_speed  = DATA_W'(-speed_reg);

        fire      = armed_reg && ((in_now_reg - quiet_reg) >= {16'd0, cfg_quiet_reg});
        timed_out = !in_seen_reg && (fill_reg != '0)
                    && ((in_time_reg - last_reg) > cfg_timeout_reg);
    end

    always_comb begin
        state_next       = state_reg;
        in_neg_next      = in_neg_reg;
        in_time_next     = in_time_reg;
        in_now_next      = in_now_reg;
        in_seen_next     = in_seen_reg;
        cfg_window_next  = cfg_window_reg;
        cfg_speed_next   = cfg_speed_reg;
        cfg_steps_next   = cfg_steps_reg;
        cfg_quiet_next   = cfg_quiet_reg;
        cfg_timeout_next = cfg_timeout_reg;
        ptr_next         = ptr_reg;
        fill_next        = fill_reg;
        last_next        = last_reg;
        num_next         = num_reg;
        rev_next         = rev_reg;
        speed_next       = speed_reg;
        prior_valid_next = prior_valid_reg;
        prior_neg_next   = prior_neg_reg;
        rev_times_next   = rev_times_reg;
        rev_fill_next    = rev_fill_reg;
        tms_next         = tms_reg;
        armed_next       = armed_reg;
        burst_next       = burst_reg;
        peak_next        = peak_reg;
        quiet_next       = quiet_reg;
        delta_next       = delta_reg;
        res_gest_next    = res_gest_reg;
        res_delta_next   = res_delta_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        div_start        = 1'b0;
        div_dividend     = num_reg;
        div_divisor      = dt;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SHAKE_WINDOW: cfg_window_next  = cfg_data[15:0];
                CFG_MIN_SPEED:    cfg_speed_next   = cfg_data[15:0];
                CFG_MIN_STEPS:    cfg_steps_next   = cfg_data[7:0];
                CFG_QUIET_MS:     cfg_quiet_next   = cfg_data[15:0];
                CFG_TIMEOUT_US:   cfg_timeout_next = cfg_data;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    in_neg_next    = (s_tdata[1:0] != DIR_CW);
                    in_time_next   = s_tdata[33:2];
                    in_now_next    = s_tdata[65:34];
                    in_seen_next   = s_tdata[66];
                    res_gest_next  = GEST_NONE;
                    res_delta_next = '0;
                    state_next     = ST_DONE;
                    case (s_tuser)
                        KIND_STEP: begin
                            if (s_tdata[1:0] != DIR_NONE) begin
                                state_next = ST_RING;
                            end
                        end
                        KIND_POLL: state_next = ST_PARM;
                        KIND_READ: begin
                            res_delta_next = delta_reg;
                            delta_next     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RING: begin
                delta_next = in_neg_reg ? delta_reg - 1'b1 : delta_reg + 1'b1;
                ptr_next   = (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                fill_next  = fill_inc;
                last_next  = in_time_reg;
                num_next   = DATA_W'(DATA_W'(fill_inc - 1'b1) * VEL_SCALE);
                rev_next   = prior_valid_reg && (in_neg_reg != prior_neg_reg);
                state_next = ST_OLD;
            end
            ST_OLD: begin
                if ((fill_reg >= FILL_W'(2)) && (dt != '0)) begin
                    div_start  = 1'b1;
                    state_next = ST_VDIV;
                end else begin
                    state_next = ST_REV;
                end
            end
            ST_VDIV: begin
                if (div_stat.done) begin
                    speed_next = in_neg_reg ? DATA_W'(-mag) : mag;
                    state_next = ST_REV;
                end
            end
            ST_REV: begin
                if (rev_reg) begin
                    tms_next   = DATA_W'(ms_prod >> MS_SHIFT);
                    state_next = ST_MDIV;
                end else begin
                    state_next = ST_BURST;
                end
            end
            ST_MDIV: begin
                if (rev_fill_reg == RF_W'(REVERSALS + 1)) begin
                    for (int i = 0; i < REVERSALS; i++) begin
                        rev_times_next[i] = rev_times_reg[i+1];
                    end
                    rev_times_next[REVERSALS] = tms_reg;
                end else begin
                    rev_times_next[rev_fill_reg[RI_W-1:0]] = tms_reg;
                    rev_fill_next = rev_fill_reg + 1'b1;
                end
                state_next = ST_SHAKE;
            end
            ST_SHAKE: begin
                if (shake_hit) begin
                    rev_fill_next = '0;
                    armed_next    = 1'b0;
                    burst_next    = '0;
                    delta_next    = '0;
                    res_gest_next = GEST_SHAKE;
                    state_next    = ST_DONE;
                end else begin
                    state_next = ST_BURST;
                end
            end
            ST_BURST: begin
                prior_valid_next = 1'b1;
                prior_neg_next   = in_neg_reg;
                if (burst_fast) begin
                    if (burst_reg != 8'hFF) begin
                        burst_next = burst_reg + 1'b1;
                    end
                    armed_next = 1'b0;
                    if (neg_speed > peak_reg) begin
                        peak_next = neg_speed;
                    end
                end else if (!in_neg_reg) begin
                    burst_next = '0;
                    armed_next = 1'b0;
                    peak_next  = '0;
                end
                state_next = ST_DONE;
            end
            ST_PARM: begin
                if (!armed_reg && (burst_reg >= cfg_steps_reg) && !in_seen_reg) begin
                    armed_next = 1'b1;
                    quiet_next = in_now_reg;
                end
                state_next = ST_PCHK;
            end
            ST_PCHK: begin
                if (fire) begin
                    armed_next    = 1'b0;
                    burst_next    = '0;
                    peak_next     = '0;
                    delta_next    = '0;
                    res_gest_next = GEST_BACKSPIN;
                end else if (timed_out) begin
                    speed_next = '0;
                    fill_next  = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_delta_reg, speed_reg};
                    m_tuser_next  = res_gest_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cfg_window_reg  <= RST_SHAKE_WINDOW;
            cfg_speed_reg   <= RST_MIN_SPEED;
            cfg_steps_reg   <= RST_MIN_STEPS;
            cfg_quiet_reg   <= RST_QUIET_MS;
            cfg_timeout_reg <= RST_TIMEOUT_US;
            ptr_reg         <= '0;
            fill_reg        <= '0;
            speed_reg       <= '0;
            prior_valid_reg <= 1'b0;
            prior_neg_reg   <= 1'b0;
            rev_fill_reg    <= '0;
            armed_reg       <= 1'b0;
            burst_reg       <= '0;
            peak_reg        <= '0;
            quiet_reg       <= '0;
            delta_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cfg_window_reg  <= cfg_window_next;
            cfg_speed_reg   <= cfg_speed_next;
            cfg_steps_reg   <= cfg_steps_next;
            cfg_quiet_reg   <= cfg_quiet_next;
            cfg_timeout_reg <= cfg_timeout_next;
            ptr_reg         <= ptr_next;
            fill_reg        <= fill_next;
            speed_reg       <= speed_next;
            prior_valid_reg <= prior_valid_next;
            prior_neg_reg   <= prior_neg_next;
            rev_fill_reg    <= rev_fill_next;
            armed_reg       <= armed_next;
            burst_reg       <= burst_next;
            peak_reg        <= peak_next;
            quiet_reg       <= quiet_next;
            delta_reg       <= delta_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        in_neg_reg    <= in_neg_next;
        in_time_reg   <= in_time_next;
        in_now_reg    <= in_now_next;
        in_seen_reg   <= in_seen_next;
        last_reg      <= last_next;
        num_reg       <= num_next;
        rev_reg       <= rev_next;
        rev_times_reg <= rev_times_next;
        tms_reg       <= tms_next;
        res_gest_reg  <= res_gest_next;
        res_delta_reg <= res_delta_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(RING_DEPTH) && rev_fill_reg <= RF_W'(REVERSALS + 1))
        else $error("ring or reversal fill out of range");
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
    a_shake_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        shake_hit |=> rev_fill_reg == '0 && !armed_reg && burst_reg == '0
                      && delta_reg == '0)
        else $error("shake did not clear gesture state");
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        speed_reg != 32'h8000_0000)
        else $error("velocity left the saturated range");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import egd_pkg::*;

    localparam int RING_N  = RING_DEPTH_DEF;
    localparam int REV_N   = REVERSALS_DEF;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int LONG_HOLD_CYCLES = 700;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 212;

    localparam logic [1:0] KIND_BAD    = 2'd3;
    localparam logic [1:0] DIR_CCW     = 2'b11;
    localparam logic [1:0] DIR_CCW_ALT = 2'b10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int RX_OPEN   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_TICK   = 3;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  dir;
        logic [31:0] time_us;
        logic [31:0] now_ms;
        logic        seen;
    } encoder_txn_t;

    typedef struct packed {
        logic [1:0]  gesture;
        logic [31:0] velocity;
        logic [7:0]  delta;
    } gesture_report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data = '0;

    encoder_gesture_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    logic [31:0] win_ms, min_speed, min_steps, quiet_ms, timeout_us;
    logic [31:0] stamp_ring [RING_N];
    int unsigned ring_wr, ring_cnt;
    int          vel_now;
    int          prev_dir;
    logic [31:0] rev_ms [REV_N+1];
    int unsigned rev_cnt;
    bit          quiet_armed;
    int unsigned burst_cnt;
    logic [31:0] quiet_t0;
    logic [7:0]  delta_acc;

    encoder_txn_t    encoder_feed [$];
    gesture_report_t pending_reports [$];
    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              live_items;
    logic [31:0]     cur_us, cur_ms;
    bit              offer_taken = 1'b0;
    int              burst_left = 0;
    int              gap_left = 0;
    bit              long_hold_go = 1'b0;
    bit              long_hold = 1'b0;
    int              rx_mode = RX_OPEN;
    int              rx_left = 0;
    int              rx_tick = 0;
    gesture_report_t due;

    task automatic reset_predictor();
        win_ms     = 32'(RST_SHAKE_WINDOW);
        min_speed  = 32'(RST_MIN_SPEED);
        min_steps  = 32'(RST_MIN_STEPS);
        quiet_ms   = 32'(RST_QUIET_MS);
        timeout_us = RST_TIMEOUT_US;
        foreach (stamp_ring[i]) stamp_ring[i] = '0;
        foreach (rev_ms[i]) rev_ms[i] = '0;
        ring_wr = 0;
        ring_cnt = 0;
        vel_now = 0;
        prev_dir = 0;
        rev_cnt = 0;
        quiet_armed = 1'b0;
        burst_cnt = 0;
        quiet_t0 = '0;
        delta_acc = '0;
    endtask

    task automatic take_step(input int d, input logic [31:0] t, output logic [1:0] g);
        logic [31:0] oldest, newest, dt, t_ms, first;
        logic [63:0] mag;
        int          j;
        g = GEST_NONE;
        delta_acc = delta_acc + ((d > 0) ? 8'h01 : 8'hFF);
        stamp_ring[ring_wr] = t;
        ring_wr = (ring_wr + 1) % RING_N;
        if (ring_cnt < RING_N) ring_cnt++;
        if (ring_cnt >= 2) begin
            oldest = stamp_ring[(ring_wr + RING_N - ring_cnt) % RING_N];
            newest = stamp_ring[(ring_wr + RING_N - 1) % RING_N];
            dt = newest - oldest;
            if (dt != 0) begin
                mag = 64'(ring_cnt - 1) * 64'd256000000 / {32'd0, dt};
                if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
                vel_now = (d < 0) ? -int'(mag[31:0]) : int'(mag[31:0]);
            end
        end
        if (prev_dir != 0 && d != prev_dir) begin
            t_ms = t / 1000;
            if (rev_cnt < REV_N + 1) begin
                rev_ms[rev_cnt] = t_ms;
                rev_cnt++;
            end else begin
                for (j = 0; j < REV_N; j++) rev_ms[j] = rev_ms[j+1];
                rev_ms[REV_N] = t_ms;
            end
            if (rev_cnt >= REV_N) begin
                first = rev_ms[rev_cnt - REV_N];
                if (t_ms - first <= win_ms) begin
                    rev_cnt = 0;
                    quiet_armed = 1'b0;
                    burst_cnt = 0;
                    delta_acc = '0;
                    g = GEST_SHAKE;
                    return;
                end
            end
        end
        prev_dir = d;
        if (d < 0 && longint'(vel_now) < -(longint'(min_speed) * 256)) begin
            if (burst_cnt < 255) burst_cnt++;
            quiet_armed = 1'b0;
        end else if (d > 0) begin
            burst_cnt = 0;
            quiet_armed = 1'b0;
        end
    endtask

    task automatic close_poll(input logic [31:0] tu, input logic [31:0] tm, input logic sn,
                              output logic [1:0] g);
        logic [31:0] last;
        g = GEST_NONE;
        if (!quiet_armed && burst_cnt >= min_steps && !sn) begin
            quiet_armed = 1'b1;
            quiet_t0 = tm;
        end
        if (quiet_armed && (tm - quiet_t0) >= quiet_ms) begin
            quiet_armed = 1'b0;
            burst_cnt = 0;
            delta_acc = '0;
            g = GEST_BACKSPIN;
            return;
        end
        if (!sn && ring_cnt > 0) begin
            last = stamp_ring[(ring_wr + RING_N - 1) % RING_N];
            if (tu - last > timeout_us) begin
                vel_now = 0;
                ring_cnt = 0;
            end
        end
    endtask

    task automatic detect_gesture(input encoder_txn_t x, output gesture_report_t r);
        logic [1:0] g;
        g = GEST_NONE;
        r.delta = '0;
        case (x.kind)
            KIND_STEP: begin
                if (x.dir != DIR_NONE) take_step((x.dir == DIR_CW) ? 1 : -1, x.time_us, g);
            end
            KIND_POLL: close_poll(x.time_us, x.now_ms, x.seen, g);
            KIND_READ: begin
                r.delta = delta_acc;
                delta_acc = '0;
            end
            default: ;
        endcase
        r.gesture = g;
        r.velocity = vel_now;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SHAKE_WINDOW: win_ms     = val & 32'hFFFF;
            CFG_MIN_SPEED:    min_speed  = val & 32'hFFFF;
            CFG_MIN_STEPS:    min_steps  = val & 32'hFF;
            CFG_QUIET_MS:     quiet_ms   = val & 32'hFFFF;
            CFG_TIMEOUT_US:   timeout_us = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] junk_hi(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = (32'h1 << bits) - 1;
        return ($urandom & ~m) | (v & m);
    endfunction

    task automatic program_phase(input int ph);
        logic [31:0] w, sp, st, q, to;
        case (ph)
            0: begin w = 65535; sp = 0; st = 1; q = 0; to = 32'hFFFF_FFFF; end
            1: begin w = 0; sp = 65535; st = 255; q = 65535; to = 0; end
            2: begin w = 600; sp = 30; st = 0; q = 150; to = 200000; end
            default: begin
                w  = $urandom_range(100, 3000);
                sp = $urandom_range(0, 300);
                st = $urandom_range(1, 6);
                q  = $urandom_range(0, 400);
                to = $urandom_range(2000, 800000);
            end
        endcase
        write_reg(CFG_SHAKE_WINDOW, junk_hi(w, 16));
        write_reg(CFG_MIN_SPEED, junk_hi(sp, 16));
        write_reg(CFG_MIN_STEPS, junk_hi(st, 8));
        write_reg(CFG_QUIET_MS, junk_hi(q, 16));
        write_reg(CFG_TIMEOUT_US, to);
        if (ph == 1) write_reg(CFG_UNUSED, $urandom);
    endtask

    task automatic push_item(input logic [1:0] k, input logic [1:0] d, input logic [31:0] tu,
                             input logic [31:0] tm, input logic sn);
        encoder_txn_t x;
        x.kind = k;
        x.dir = d;
        x.time_us = tu;
        x.now_ms = tm;
        x.seen = sn;
        encoder_feed.push_back(x);
        if (!(k == KIND_BAD || (k == KIND_STEP && d == DIR_NONE))) live_items++;
    endtask

    task automatic pass_us(input logic [31:0] us);
        cur_us += us;
        cur_ms += us / 1000;
    endtask

    function automatic logic [1:0] ccw_code();
        return ($urandom_range(0, 3) == 0) ? DIR_CCW_ALT : DIR_CCW;
    endfunction

    task automatic queue_scenario();
        int          pick, n, i;
        logic [1:0]  d;
        logic [31:0] gap;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            // fast ccw burst, then quiet polls
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++) begin
                pass_us($urandom_range(0, 1) ? $urandom_range(10, 2000)
                                             : $urandom_range(2000, 60000));
                push_item(KIND_STEP, ccw_code(), cur_us, cur_ms, 1'($urandom));
            end
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                gap = $urandom_range(1, 120);
                cur_ms += gap;
                cur_us += gap * 1000;
                push_item(KIND_POLL, 2'($urandom), cur_us, cur_ms,
                          $urandom_range(0, 4) == 0);
            end
        end else if (pick < 45) begin
            // back-and-forth turning
            n = $urandom_range(3, 12);
            d = $urandom_range(0, 1) ? DIR_CW : ccw_code();
            for (i = 0; i < n; i++) begin
                pass_us($urandom_range(500, 250000));
                if ($urandom_range(0, 4) != 0) d = (d == DIR_CW) ? ccw_code() : DIR_CW;
                push_item(KIND_STEP, d, cur_us, cur_ms, 1'($urandom));
            end
        end else if (pick < 60) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
                pass_us($urandom_range(1, 80000));
                push_item(KIND_STEP, DIR_CW, cur_us, cur_ms, 1'($urandom));
            end
            push_item(KIND_POLL, 2'($urandom), cur_us, cur_ms, 1'b1);
        end else if (pick < 70) begin
            push_item(KIND_READ, 2'($urandom), $urandom, $urandom, 1'($urandom));
        end else if (pick < 80) begin
            gap = (timeout_us < 32'h4000_0000) ? $urandom_range(0, timeout_us * 2 + 16)
                                               : $urandom;
            pass_us(gap);
            push_item(KIND_POLL, 2'($urandom), cur_us, cur_ms, $urandom_range(0, 3) == 0);
        end else if (pick < 85) begin
            // repeated timestamps
            n = $urandom_range(2, 4);
            for (i = 0; i < n; i++)
                push_item(KIND_STEP, $urandom_range(0, 1) ? DIR_CW : ccw_code(),
                          cur_us, cur_ms, 1'($urandom));
        end else begin
            push_item(2'($urandom), 2'($urandom), $urandom, $urandom, 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (encoder_feed.size() != 0 || pending_reports.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // input driver: offers at the falling edge, bookkeeping at the rising edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !offer_taken) begin
            // hold until the transaction is accepted
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (encoder_feed.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tuser  <= encoder_feed[0].kind;
            s_tdata  <= {5'd0, encoder_feed[0].seen, encoder_feed[0].now_ms,
                         encoder_feed[0].time_us, encoder_feed[0].dir};
            offer_taken = 1'b0;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0: gap_left = 0;
                    1: gap_left = $urandom_range(20, 60);
                    default: gap_left = $urandom_range(1, 12);
                endcase
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        gesture_report_t r;
        if (aresetn && s_tvalid && s_tready && !offer_taken) begin
            detect_gesture(encoder_feed.pop_front(), r);
            pending_reports.push_back(r);
            offer_taken = 1'b1;
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_TICK);
            rx_left = $urandom_range(20, 300);
        end else begin
            rx_left--;
        end
        rx_tick++;
        if (long_hold) begin
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_HALF:   m_tready <= 1'($urandom);
                RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
                default:   m_tready <= (rx_tick % 4 != 0);
            endcase
        end
    end

    initial begin
        while (!long_hold_go) @(posedge aclk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        long_hold = 1'b0;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("unexpected result", {30'd0, m_tuser}, '0);
            end else begin
                due = pending_reports.pop_front();
                if (m_tuser !== due.gesture)
                    flag_mismatch("gesture", {30'd0, m_tuser}, {30'd0, due.gesture});
                if (m_tdata[31:0] !== due.velocity)
                    flag_mismatch("velocity", m_tdata[31:0], due.velocity);
                if (m_tdata[39:32] !== due.delta)
                    flag_mismatch("delta", {24'd0, m_tdata[39:32]}, {24'd0, due.delta});
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int ph;
        reset_predictor();
        live_items = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset config, edge values, shake, wrap, timeout, backspin
        push_item(KIND_READ, DIR_NONE, 32'h0, 32'h0, 1'b0);
        push_item(KIND_BAD, 2'b11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(KIND_STEP, DIR_NONE, 32'd5, 32'h0, 1'b0);
        push_item(KIND_STEP, DIR_CW, 32'd0, 32'h0, 1'b0);
        push_item(KIND_STEP, DIR_CW, 32'd0, 32'h0, 1'b1);
        push_item(KIND_STEP, DIR_CW, 32'd1, 32'h0, 1'b0);
        push_item(KIND_STEP, DIR_CCW_ALT, 32'd2000, 32'd2, 1'b0);
        push_item(KIND_STEP, DIR_CCW, 32'd3000, 32'd3, 1'b0);
        push_item(KIND_STEP, DIR_CW, 32'd4000, 32'd4, 1'b0);
        push_item(KIND_STEP, DIR_CCW, 32'd5000, 32'd5, 1'b0);
        push_item(KIND_STEP, DIR_CW, 32'd6000, 32'd6, 1'b0);
        push_item(KIND_READ, DIR_NONE, 32'h0, 32'h0, 1'b0);
        push_item(KIND_STEP, DIR_CW, 32'hFFFF_FFF0, 32'h0, 1'b0);
        push_item(KIND_STEP, DIR_CW, 32'h0000_0010, 32'h0, 1'b0);
        push_item(KIND_READ, DIR_NONE, 32'h0, 32'h0, 1'b0);
        push_item(KIND_POLL, DIR_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_item(KIND_POLL, DIR_NONE, 32'h10, 32'h0, 1'b1);
        push_item(KIND_STEP, DIR_CCW, 32'd1000, 32'd1, 1'b0);
        push_item(KIND_STEP, DIR_CCW, 32'd2000, 32'd2, 1'b0);
        push_item(KIND_STEP, DIR_CCW, 32'd3000, 32'd3, 1'b0);
        push_item(KIND_STEP, DIR_CCW, 32'd4000, 32'd4, 1'b0);
        push_item(KIND_POLL, DIR_NONE, 32'd4000, 32'd100, 1'b0);
        push_item(KIND_POLL, DIR_NONE, 32'd4000, 32'd200, 1'b1);
        push_item(KIND_POLL, DIR_NONE, 32'd4000, 32'd250, 1'b0);
        push_item(KIND_READ, DIR_NONE, 32'h0, 32'h0, 1'b0);

        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            program_phase(ph);
            cur_us = $urandom;
            cur_ms = $urandom;
            live_items = 0;
            while (live_items < ITEMS_PER_PHASE) queue_scenario();
            if (ph == 2) long_hold_go = 1'b1;
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
